### sv/vsr_pkg.sv
package vsr_pkg;

    // Counting limit for vertices folded into the statistics
    localparam int MAX_VERTICES = 1024;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int SCALE_W  = 16;
    localparam int PROD_W   = COORD_W + SCALE_W;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int RADIUS_W = 32;
    localparam int TOTAL_W  = 11;
    localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W    = RADIUS_W + $clog2(MAX_VERTICES);

    // Stream word layout
    localparam int IN_DATA_W   = 3 * COORD_W;
    localparam int OUT_FIELD_W = 3 * COORD_W + 2 * RADIUS_W + TOTAL_W + 1;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 2'd2;

    localparam logic signed [SCALE_W-1:0] SCALE_ONE = 16'sd256;

    // Input action and result kind codes
    localparam logic ACT_VERTEX   = 1'b0;
    localparam logic ACT_FINISH   = 1'b1;
    localparam logic KIND_VERTEX  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [COORD_W-1:0]  scaled_x;
        logic signed [COORD_W-1:0]  scaled_y;
        logic signed [COORD_W-1:0]  scaled_z;
        logic        [RADIUS_W-1:0] rad_max;
        logic        [RADIUS_W-1:0] rad_mean;
        logic        [TOTAL_W-1:0]  vertex_total;
        logic                       overflow;
    } t_result;

endpackage

### sv/vertex_scale_radius_stats.sv
// Vertex scaler with bounding-sphere radius statistics. Each vertex word (tuser = 0)
// carries Q16.16 x, y, z; three axis lanes scale them by the signed Q8.8 registers with
// floor rounding and 32-bit saturation, and the merge stage takes the floor square root of
// the squared distance and folds it into a running maximum, sum and count. A finish word
// (tuser = 1) returns maximum, floor average and count, then clears the statistics.
// Vertices past MAX_VERTICES are still scaled but only set the overflow flag. The block
// works on one word at a time: a vertex waits for the 32-step square root, a finish with
// vertices counted for the 42-step divider; a finish with no vertices counted skips it.
// A finished result waits in the output register while the next word is taken in. The
// user must write the scale registers only while idle; the block does not enforce this.
module vertex_scale_radius_stats (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [vsr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [vsr_pkg::SCALE_W-1:0]           i_cfg_data,
    // input words
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [vsr_pkg::IN_DATA_W-1:0]         i_s_axis_tdata,  // coord_x, coord_y, coord_z
    input  logic                                  i_s_axis_tuser,  // action
    // result words
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // scaled_x, scaled_y, scaled_z, max radius, mean radius, vertex_total, overflow, pad
    output logic [vsr_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,
    output logic                                  o_m_axis_tuser   // kind
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LANE = 5'b00010,
        S_ROOT = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    localparam int CW = vsr_pkg::COORD_W;

    t_state                                r_state;
    logic [1:0]                            r_wait;
    logic signed [vsr_pkg::SCALE_W-1:0]    r_scale_x;
    logic signed [vsr_pkg::SCALE_W-1:0]    r_scale_y;
    logic signed [vsr_pkg::SCALE_W-1:0]    r_scale_z;
    logic signed [CW-1:0]                  r_cx;
    logic signed [CW-1:0]                  r_cy;
    logic signed [CW-1:0]                  r_cz;
    logic [vsr_pkg::RADIUS_W-1:0]          r_max;
    logic [vsr_pkg::SUM_W-1:0]             r_sum;
    logic [vsr_pkg::CNT_W-1:0]             r_count;
    logic                                  r_ovf;
    vsr_pkg::t_result                      r_res;
    vsr_pkg::t_result                      r_out;
    logic                                  r_out_valid;

    logic                                  in_fire;
    logic                                  sqrt_start;
    logic                                  sqrt_done;
    logic [vsr_pkg::RADIUS_W-1:0]          sqrt_root;
    logic [vsr_pkg::SQ_W-1:0]              dist_sq;
    logic                                  div_start;
    logic                                  div_done;
    logic [vsr_pkg::SUM_W-1:0]             div_quo;
    logic signed [CW-1:0]                  lane_x;
    logic signed [CW-1:0]                  lane_y;
    logic signed [CW-1:0]                  lane_z;
    logic [vsr_pkg::SQ_W-1:0]              sq_x;
    logic [vsr_pkg::SQ_W-1:0]              sq_y;
    logic [vsr_pkg::SQ_W-1:0]              sq_z;
    logic                                  counted;
    logic [vsr_pkg::CNT_W-1:0]             n_count;

    // axis lanes
    vsr_lane u_lane_x (.i_clk(i_clk), .i_coord(r_cx), .i_scale(r_scale_x),
                       .o_scaled(lane_x), .o_square(sq_x));
    vsr_lane u_lane_y (.i_clk(i_clk), .i_coord(r_cy), .i_scale(r_scale_y),
                       .o_scaled(lane_y), .o_square(sq_y));
    vsr_lane u_lane_z (.i_clk(i_clk), .i_coord(r_cz), .i_scale(r_scale_z),
                       .o_scaled(lane_z), .o_square(sq_z));

    // merge: squared distance fits 64 bits since each square is at most 2^62
    assign dist_sq    = sq_x + sq_y + sq_z;
    assign sqrt_start = (r_state == S_LANE) && (r_wait == 2'd3);

    vsr_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (dist_sq),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign div_start       = in_fire && (i_s_axis_tuser == vsr_pkg::ACT_FINISH)
                             && (r_count != '0);

    vsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign counted = (r_count < vsr_pkg::CNT_W'(vsr_pkg::MAX_VERTICES));
    assign n_count = counted ? r_count + 1'b1 : r_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= vsr_pkg::SCALE_ONE;
            r_scale_y <= vsr_pkg::SCALE_ONE;
            r_scale_z <= vsr_pkg::SCALE_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vsr_pkg::CFG_SCALE_X: r_scale_x <= i_cfg_data;
                vsr_pkg::CFG_SCALE_Y: r_scale_y <= i_cfg_data;
                vsr_pkg::CFG_SCALE_Z: r_scale_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: load on handover, drain on acceptance
            if ((r_state == S_DONE) && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_wait <= '0;
                        r_cx   <= i_s_axis_tdata[CW-1:0];
                        r_cy   <= i_s_axis_tdata[2*CW-1:CW];
                        r_cz   <= i_s_axis_tdata[3*CW-1:2*CW];
                        if (i_s_axis_tuser == vsr_pkg::ACT_FINISH) begin
                            r_res.kind       <= vsr_pkg::KIND_SUMMARY;
                            r_res.scaled_x   <= '0;
                            r_res.scaled_y   <= '0;
                            r_res.scaled_z   <= '0;
                            r_res.rad_max    <= '0;
                            r_res.rad_mean   <= '0;
                            r_res.vertex_total <= '0;
                            r_res.overflow   <= r_ovf;
                            if (r_count == '0) begin
                                r_ovf   <= 1'b0;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end else begin
                            r_state <= S_LANE;
                        end
                    end
                end
                S_LANE: begin
                    // wait for the lane pipes to fill; the root starts when r_wait reaches its top value
                    if (r_wait == 2'd3) begin
                        r_res.kind       <= vsr_pkg::KIND_VERTEX;
                        r_res.scaled_x   <= lane_x;
                        r_res.scaled_y   <= lane_y;
                        r_res.scaled_z   <= lane_z;
                        r_res.rad_max    <= '0;
                        r_res.rad_mean   <= '0;
                        r_state          <= S_ROOT;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_ROOT: begin
                    if (sqrt_done) begin
                        if (counted) begin
                            if (sqrt_root > r_max) begin
                                r_max <= sqrt_root;
                            end
                            r_sum <= r_sum + vsr_pkg::SUM_W'(sqrt_root);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_count            <= n_count;
                        r_res.vertex_total <= vsr_pkg::TOTAL_W'(n_count);
                        r_res.overflow     <= r_ovf | ~counted;
                        r_state            <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res.rad_max      <= r_max;
                        r_res.rad_mean     <= div_quo[vsr_pkg::RADIUS_W-1:0];
                        r_res.vertex_total <= vsr_pkg::TOTAL_W'(r_count);
                        r_max   <= '0;
                        r_sum   <= '0;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {{vsr_pkg::OUT_PAD_W{1'b0}}, r_out.overflow, r_out.vertex_total,
                              r_out.rad_mean, r_out.rad_max,
                              r_out.scaled_z, r_out.scaled_y, r_out.scaled_x};

endmodule

### sv/vsr_lane.sv
// One axis lane: scale by Q8.8, floor, saturate, then square the magnitude.
// Free-running three-stage pipe; inputs are held stable by the caller.
module vsr_lane (
    input  logic                                 i_clk,
    input  logic signed [vsr_pkg::COORD_W-1:0]   i_coord,
    input  logic signed [vsr_pkg::SCALE_W-1:0]   i_scale,
    output logic signed [vsr_pkg::COORD_W-1:0]   o_scaled,
    output logic        [vsr_pkg::SQ_W-1:0]      o_square
);

    logic signed [vsr_pkg::PROD_W-1:0]  r_prod;
    logic signed [vsr_pkg::COORD_W-1:0] r_scaled;
    logic        [vsr_pkg::COORD_W-1:0] r_mag;
    logic        [vsr_pkg::SQ_W-1:0]    r_sq;
    logic signed [vsr_pkg::COORD_W-1:0] n_scaled;
    logic        [vsr_pkg::COORD_W-1:0] n_mag;

    // Floor shift by 8 is the upper product bits; saturate when they do not fit
    always_comb begin
        if (r_prod[vsr_pkg::PROD_W-1:vsr_pkg::COORD_W+7]
                == {(vsr_pkg::PROD_W-vsr_pkg::COORD_W-7){r_prod[vsr_pkg::PROD_W-1]}}) begin
            n_scaled = r_prod[vsr_pkg::COORD_W+7:8];
        end else if (r_prod[vsr_pkg::PROD_W-1]) begin
            n_scaled = {1'b1, {(vsr_pkg::COORD_W-1){1'b0}}};
        end else begin
            n_scaled = {1'b0, {(vsr_pkg::COORD_W-1){1'b1}}};
        end
        // the most negative value negates to itself, which is its magnitude
        n_mag = n_scaled[vsr_pkg::COORD_W-1] ? (~n_scaled + 1'b1) : n_scaled;
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= i_coord * i_scale;
        r_scaled <= n_scaled;
        r_mag    <= n_mag;
        r_sq     <= r_mag * r_mag;
    end

    assign o_scaled = r_scaled;
    assign o_square = r_sq;

endmodule

### sv/vsr_sqrt.sv
// Floor square root, one result bit per cycle (restoring digit recurrence).
module vsr_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [vsr_pkg::SQ_W-1:0]        i_radicand,
    output logic                            o_done,
    output logic [vsr_pkg::RADIUS_W-1:0]    o_root
);

    localparam int STEP_W = $clog2(vsr_pkg::RADIUS_W);
    localparam int REM_W  = vsr_pkg::RADIUS_W + 2;

    logic                            r_busy;
    logic                            r_done;
    logic [STEP_W-1:0]               r_step;
    logic [vsr_pkg::SQ_W-1:0]        r_rad;
    logic [REM_W-1:0]                r_rem;
    logic [vsr_pkg::RADIUS_W-1:0]    r_root;
    logic [REM_W+1:0]                n_shift;
    logic [REM_W+1:0]                n_trial;

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
        n_shift = {r_rem, r_rad[vsr_pkg::SQ_W-1:vsr_pkg::SQ_W-2]};
        n_trial = {2'b00, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // done pulses after the last step
            r_done <= !i_start && r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(vsr_pkg::RADIUS_W - 1);
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[vsr_pkg::SQ_W-3:0], 2'b00};
                if (n_shift >= n_trial) begin
                    r_rem  <= REM_W'(n_shift - n_trial);
                    r_root <= {r_root[vsr_pkg::RADIUS_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(n_shift);
                    r_root <= {r_root[vsr_pkg::RADIUS_W-2:0], 1'b0};
                end
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### sv/vsr_div.sv
// Restoring divider for the average radius, one quotient bit per cycle.
module vsr_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [vsr_pkg::SUM_W-1:0]       i_dividend,
    input  logic [vsr_pkg::CNT_W-1:0]       i_divisor,
    output logic                            o_done,
    output logic [vsr_pkg::SUM_W-1:0]       o_quotient
);

    localparam int STEP_W = $clog2(vsr_pkg::SUM_W);

    logic                            r_busy;
    logic                            r_done;
    logic [STEP_W-1:0]               r_step;
    logic [vsr_pkg::SUM_W-1:0]       r_quo;
    logic [vsr_pkg::CNT_W-1:0]       r_rem;
    logic [vsr_pkg::CNT_W-1:0]       r_den;
    logic [vsr_pkg::CNT_W:0]         n_shift;

    assign n_shift = {r_rem, r_quo[vsr_pkg::SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // done pulses after the last step
            r_done <= !i_start && r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(vsr_pkg::SUM_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                // dividend bits shift out on top, quotient bits shift in below
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem <= vsr_pkg::CNT_W'(n_shift - {1'b0, r_den});
                    r_quo <= {r_quo[vsr_pkg::SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= vsr_pkg::CNT_W'(n_shift);
                    r_quo <= {r_quo[vsr_pkg::SUM_W-2:0], 1'b0};
                end
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
